// ----- sv/ray_sphere_intersect_assert.svh -----
// Assertion macros shared by the ray / sphere intersection modules.
`ifndef RAY_SPHERE_INTERSECT_ASSERT_SVH
`define RAY_SPHERE_INTERSECT_ASSERT_SVH

`ifndef SYNTHESIS

// Checked on every rising edge of clk once reset is released.
`define RSI_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("ray sphere intersect: assertion failed");

// Checked on every rising edge of clk, reset included.
`define RSI_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("ray sphere intersect: reset assertion failed");

`else

`define RSI_ASSERT(lbl, prop)
`define RSI_ASSERT_RST(lbl, prop)

`endif

`endif

// ----- sv/rsi_pkg.sv -----
// Types, widths and register codes of the ray / sphere intersection block.
package rsi_pkg;

  // Field widths of the ports.
  localparam int COORD_W = 32;
  localparam int DIR_W   = 16;
  localparam int R_W     = 31;
  localparam int DIST_W  = 31;

  // Configuration port.
  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 32;
  localparam int IDX_W   = 2;

  // Intermediate widths, each just wide enough for its value range.
  localparam int M_W     = COORD_W + 1;       // origin - centre
  localparam int PMD_W   = M_W + DIR_W;       // m * dir
  localparam int MSQ_W   = 2 * COORD_W + 1;   // |m|^2, at most 2^64
  localparam int RSQ_W   = 2 * R_W;           // r^2
  localparam int SXY_W   = MSQ_W + 1;         // |mx|^2 + |my|^2
  localparam int SZR_W   = MSQ_W + 1;         // |mz|^2 - r^2, signed
  localparam int C_W     = MSQ_W + 2;         // m.m - r^2, signed
  localparam int B_W     = PMD_W + 1;         // m.dir, signed
  localparam int BMAG_W  = B_W - 1;           // |b|
  localparam int BL_W    = (BMAG_W + 1) / 2;  // low half of |b|
  localparam int BH_W    = BMAG_W - BL_W;     // high half of |b|
  localparam int BSQ_W   = 2 * BMAG_W;        // b^2
  localparam int CSHIFT  = 28;                // Q.32 to Q.60
  localparam int RAD_W   = BSQ_W + 2;         // discriminant, signed
  localparam int ROOT_W  = RAD_W / 2;         // square root bits
  localparam int REM_W   = ROOT_W + 2;        // partial remainder
  localparam int T_W     = B_W + 2;           // -b - s, signed
  localparam int TSHIFT  = 14;                // Q.30 to Q.16

  // Register reset values.
  localparam logic [COORD_W-1:0] CENTER_RESET = '0;
  localparam logic [R_W-1:0]     RADIUS_RESET = R_W'(1310720);

  // Register indexes on the configuration port.
  localparam logic [IDX_W-1:0] REG_CENTER_X = 2'd0;
  localparam logic [IDX_W-1:0] REG_CENTER_Y = 2'd1;
  localparam logic [IDX_W-1:0] REG_CENTER_Z = 2'd2;
  localparam logic [IDX_W-1:0] REG_RADIUS   = 2'd3;

  // One ray request.
  typedef struct packed {
    logic signed [COORD_W-1:0] origin_x;
    logic signed [COORD_W-1:0] origin_y;
    logic signed [COORD_W-1:0] origin_z;
    logic signed [DIR_W-1:0]   dir_x;
    logic signed [DIR_W-1:0]   dir_y;
    logic signed [DIR_W-1:0]   dir_z;
  } rsi_in_t;

  // One intersection result.
  typedef struct packed {
    logic              hit;
    logic [DIST_W-1:0] entry_distance;
  } rsi_out_t;

  // Data handed from one square root cell to the next.
  typedef struct packed {
    logic                  valid;
    logic                  hit;
    logic signed [B_W-1:0] b;
    logic [RAD_W-1:0]      rad;
    logic [REM_W-1:0]      rem;
    logic [ROOT_W-1:0]     root;
  } rsi_cell_t;

endpackage

// ----- sv/rsi_front.sv -----
// Front pipeline: forms b = m.dir, c = m.m - r^2 and the discriminant.
module rsi_front import rsi_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  rsi_in_t             in_payload,
  input  logic [COORD_W-1:0]  center_x,
  input  logic [COORD_W-1:0]  center_y,
  input  logic [COORD_W-1:0]  center_z,
  input  logic [R_W-1:0]      radius,
  output rsi_cell_t           head
);

  // Stage valid bits.
  logic s1_v_r, s2_v_r, s3_v_r, s4_v_r, s5_v_r, s6_v_r;

  // Stage 1: offset from the centre.
  logic signed [M_W-1:0]   s1_mx_nxt, s1_my_nxt, s1_mz_nxt;
  logic signed [M_W-1:0]   s1_mx_r, s1_my_r, s1_mz_r;
  logic signed [DIR_W-1:0] s1_dx_r, s1_dy_r, s1_dz_r;

  // Stage 2: products.
  logic [M_W-1:0]            mag_x, mag_y, mag_z;
  logic signed [PMD_W-1:0]   s2_pmd_x_nxt, s2_pmd_y_nxt, s2_pmd_z_nxt;
  logic signed [PMD_W-1:0]   s2_pmd_x_r, s2_pmd_y_r, s2_pmd_z_r;
  logic [MSQ_W-1:0]          s2_msq_x_nxt, s2_msq_y_nxt, s2_msq_z_nxt;
  logic [MSQ_W-1:0]          s2_msq_x_r, s2_msq_y_r, s2_msq_z_r;
  logic [RSQ_W-1:0]          s2_rsq_nxt, s2_rsq_r;

  // Stage 3: partial sums.
  logic signed [B_W-1:0]   s3_b_nxt, s3_b_r;
  logic [SXY_W-1:0]        s3_sxy_nxt, s3_sxy_r;
  logic signed [SZR_W-1:0] s3_szr_nxt, s3_szr_r;

  // Stage 4: c and |b|.
  logic signed [C_W-1:0]   s4_c_nxt, s4_c_r;
  logic signed [B_W-1:0]   s4_b_r;
  logic [BMAG_W-1:0]       s4_bmag_nxt, s4_bmag_r;

  // Stage 5: partial products of b^2 and the early miss test.
  logic [BH_W-1:0]         bh;
  logic [BL_W-1:0]         bl;
  logic [2*BH_W-1:0]       s5_pp_hh_nxt, s5_pp_hh_r;
  logic [BH_W+BL_W-1:0]    s5_pp_hl_nxt, s5_pp_hl_r;
  logic [2*BL_W-1:0]       s5_pp_ll_nxt, s5_pp_ll_r;
  logic                    s5_em_nxt, s5_em_r;
  logic signed [C_W-1:0]   s5_c_r;
  logic signed [B_W-1:0]   s5_b_r;

  // Stage 6: b^2.
  logic [BSQ_W-1:0]        s6_bsq_nxt, s6_bsq_r;
  logic signed [C_W-1:0]   s6_c_r;
  logic signed [B_W-1:0]   s6_b_r;
  logic                    s6_em_r;

  // Stage 7: discriminant, loaded into the head of the cell chain.
  logic signed [RAD_W-1:0] discr;
  rsi_cell_t               head_nxt, head_r;

  // Stage 1 logic: m = origin - centre at full width.
  always_comb begin
    s1_mx_nxt = $signed({in_payload.origin_x[COORD_W-1], in_payload.origin_x})
              - $signed({center_x[COORD_W-1], center_x});
    s1_my_nxt = $signed({in_payload.origin_y[COORD_W-1], in_payload.origin_y})
              - $signed({center_y[COORD_W-1], center_y});
    s1_mz_nxt = $signed({in_payload.origin_z[COORD_W-1], in_payload.origin_z})
              - $signed({center_z[COORD_W-1], center_z});
  end

  // Stage 2 logic: one multiplier per product.
  always_comb begin
    mag_x        = s1_mx_r[M_W-1] ? M_W'(-s1_mx_r) : M_W'(s1_mx_r);
    mag_y        = s1_my_r[M_W-1] ? M_W'(-s1_my_r) : M_W'(s1_my_r);
    mag_z        = s1_mz_r[M_W-1] ? M_W'(-s1_mz_r) : M_W'(s1_mz_r);
    s2_pmd_x_nxt = s1_mx_r * s1_dx_r;
    s2_pmd_y_nxt = s1_my_r * s1_dy_r;
    s2_pmd_z_nxt = s1_mz_r * s1_dz_r;
    s2_msq_x_nxt = mag_x * mag_x;
    s2_msq_y_nxt = mag_y * mag_y;
    s2_msq_z_nxt = mag_z * mag_z;
    s2_rsq_nxt   = radius * radius;
  end

  // Stage 3 logic: dot product and the first half of m.m - r^2.
  always_comb begin
    s3_b_nxt   = B_W'(s2_pmd_x_r) + B_W'(s2_pmd_y_r) + B_W'(s2_pmd_z_r);
    s3_sxy_nxt = SXY_W'(s2_msq_x_r) + SXY_W'(s2_msq_y_r);
    s3_szr_nxt = $signed(SZR_W'(s2_msq_z_r)) - $signed(SZR_W'(s2_rsq_r));
  end

  // Stage 4 logic: c and the magnitude of b.
  always_comb begin
    s4_c_nxt    = $signed(C_W'(s3_sxy_r)) + C_W'(s3_szr_r);
    s4_bmag_nxt = s3_b_r[B_W-1] ? BMAG_W'(-s3_b_r) : BMAG_W'(s3_b_r);
  end

  // Stage 5 logic: b^2 split into three narrow products.
  always_comb begin
    bh           = s4_bmag_r[BMAG_W-1:BL_W];
    bl           = s4_bmag_r[BL_W-1:0];
    s5_pp_hh_nxt = bh * bh;
    s5_pp_hl_nxt = bh * bl;
    s5_pp_ll_nxt = bl * bl;
    // Outside the sphere and pointing away: a miss.
    s5_em_nxt    = !s4_c_r[C_W-1] && (s4_c_r != '0) && !s4_b_r[B_W-1] && (s4_b_r != '0);
  end

  // Stage 6 logic: the outer products do not overlap, so they concatenate.
  always_comb begin
    s6_bsq_nxt = BSQ_W'({s5_pp_hh_r, s5_pp_ll_r}) + (BSQ_W'(s5_pp_hl_r) << (BL_W + 1));
  end

  // Stage 7 logic: discriminant in Q.60 and the chain head.
  always_comb begin
    discr          = $signed(RAD_W'(s6_bsq_r)) - (RAD_W'(s6_c_r) <<< CSHIFT);
    head_nxt.valid = s6_v_r;
    head_nxt.hit   = !s6_em_r && !discr[RAD_W-1];
    head_nxt.b     = s6_b_r;
    head_nxt.rad   = head_nxt.hit ? RAD_W'(discr) : '0;
    head_nxt.rem   = '0;
    head_nxt.root  = '0;
  end

  // Valid bits advance with the pipeline; the chain head loads whole.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r       <= 1'b0;
      s2_v_r       <= 1'b0;
      s3_v_r       <= 1'b0;
      s4_v_r       <= 1'b0;
      s5_v_r       <= 1'b0;
      s6_v_r       <= 1'b0;
      head_r.valid <= 1'b0;
    end else if (en) begin
      s1_v_r       <= in_valid;
      s2_v_r       <= s1_v_r;
      s3_v_r       <= s2_v_r;
      s4_v_r       <= s3_v_r;
      s5_v_r       <= s4_v_r;
      s6_v_r       <= s5_v_r;
      head_r       <= head_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (en) begin
      s1_mx_r     <= s1_mx_nxt;
      s1_my_r     <= s1_my_nxt;
      s1_mz_r     <= s1_mz_nxt;
      s1_dx_r     <= in_payload.dir_x;
      s1_dy_r     <= in_payload.dir_y;
      s1_dz_r     <= in_payload.dir_z;
      s2_pmd_x_r  <= s2_pmd_x_nxt;
      s2_pmd_y_r  <= s2_pmd_y_nxt;
      s2_pmd_z_r  <= s2_pmd_z_nxt;
      s2_msq_x_r  <= s2_msq_x_nxt;
      s2_msq_y_r  <= s2_msq_y_nxt;
      s2_msq_z_r  <= s2_msq_z_nxt;
      s2_rsq_r    <= s2_rsq_nxt;
      s3_b_r      <= s3_b_nxt;
      s3_sxy_r    <= s3_sxy_nxt;
      s3_szr_r    <= s3_szr_nxt;
      s4_c_r      <= s4_c_nxt;
      s4_b_r      <= s3_b_r;
      s4_bmag_r   <= s4_bmag_nxt;
      s5_pp_hh_r  <= s5_pp_hh_nxt;
      s5_pp_hl_r  <= s5_pp_hl_nxt;
      s5_pp_ll_r  <= s5_pp_ll_nxt;
      s5_em_r     <= s5_em_nxt;
      s5_c_r      <= s4_c_r;
      s5_b_r      <= s4_b_r;
      s6_bsq_r    <= s6_bsq_nxt;
      s6_c_r      <= s5_c_r;
      s6_b_r      <= s5_b_r;
      s6_em_r     <= s5_em_r;
    end
  end

  assign head = head_r;

endmodule

// ----- sv/rsi_sqrt_cell.sv -----
// One cell of the square root chain: settles one root bit per cell.
module rsi_sqrt_cell import rsi_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      en,
  input  rsi_cell_t cell_in,
  output rsi_cell_t cell_out
);

  logic [REM_W-1:0] cur;
  logic [REM_W-1:0] trial;
  logic             ge;
  rsi_cell_t        cell_nxt, cell_r;

  // Bring down the next two radicand bits and try root*4 + 1.
  always_comb begin
    cur            = {cell_in.rem[REM_W-3:0], cell_in.rad[RAD_W-1 -: 2]};
    trial          = {cell_in.root, 2'b01};
    ge             = (cur >= trial);
    cell_nxt       = cell_in;
    cell_nxt.rem   = ge ? (cur - trial) : cur;
    cell_nxt.root  = {cell_in.root[ROOT_W-2:0], ge};
    cell_nxt.rad   = {cell_in.rad[RAD_W-3:0], 2'b00};
  end

  // Hand the partial result to the next cell; reset clears only the valid bit.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r.valid <= 1'b0;
    end else if (en) begin
      cell_r <= cell_nxt;
    end
  end

  assign cell_out = cell_r;

endmodule

// ----- sv/rsi_out.sv -----
// Entry distance, output register and skid register of the result channel.
`include "ray_sphere_intersect_assert.svh"

module rsi_out import rsi_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  rsi_cell_t tail,
  input  logic      out_stall,
  output logic      en,
  output logic      out_valid,
  output rsi_out_t  out_payload
);

  logic signed [T_W-1:0]     t30;
  logic [T_W-TSHIFT-1:0]     t16;
  rsi_out_t                  res;
  logic                      out_take;
  logic                      out_v_r, out_v_nxt;
  logic                      skid_v_r, skid_v_nxt;
  rsi_out_t                  out_pl_r, out_pl_nxt;
  rsi_out_t                  skid_pl_r, skid_pl_nxt;

  // t = -b - sqrt(discr) in Q.30, clamped at zero and saturated in Q15.16.
  always_comb begin
    t30 = -T_W'(tail.b) - $signed(T_W'(tail.root));
    t16 = t30[T_W-1] ? '0 : t30[T_W-1:TSHIFT];
    res.hit = tail.hit;
    if (!tail.hit) begin
      res.entry_distance = '0;
    end else if (t16[T_W-TSHIFT-1:DIST_W] != '0) begin
      res.entry_distance = '1;
    end else begin
      res.entry_distance = t16[DIST_W-1:0];
    end
  end

  // The pipeline moves whenever the skid register is free.
  assign en       = !skid_v_r;
  assign out_take = out_v_r && !out_stall;

  // Output register with a one-entry skid behind it.
  always_comb begin
    out_v_nxt   = out_v_r;
    out_pl_nxt  = out_pl_r;
    skid_v_nxt  = skid_v_r;
    skid_pl_nxt = skid_pl_r;
    if (skid_v_r) begin
      if (out_take) begin
        out_pl_nxt = skid_pl_r;
        skid_v_nxt = 1'b0;
      end
    end else if (tail.valid) begin
      if (out_v_r && !out_take) begin
        skid_pl_nxt = res;
        skid_v_nxt  = 1'b1;
      end else begin
        out_pl_nxt = res;
        out_v_nxt  = 1'b1;
      end
    end else if (out_take) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_pl_r  <= out_pl_nxt;
    skid_pl_r <= skid_pl_nxt;
  end

  assign out_valid   = out_v_r;
  assign out_payload = out_pl_r;

  // The skid register only fills behind a waiting result.
  `RSI_ASSERT(a_skid_behind_out, skid_v_r |-> out_v_r)
  // A miss never carries a distance.
  `RSI_ASSERT(a_miss_zero, out_v_r && !out_pl_r.hit |-> out_pl_r.entry_distance == '0)
  // Reset empties both result registers.
  `RSI_ASSERT_RST(a_reset_empty, !rst_n |=> !out_v_r && !skid_v_r)

endmodule

// ----- sv/ray_sphere_intersect.sv -----
// Ray / sphere entry test: one ray request per cycle while in_stall is low,
// one result per ray. A request passes seven front stages that form
// m = origin - centre, b = m.dir, c = m.m - r^2 and the discriminant, then a
// chain of 50 square root cells that each settle one bit of the root, and
// finally the output register, where the entry distance -b - sqrt(b^2 - c)
// is clamped at zero and saturated. A new ray is taken every cycle as long as
// results are taken; in_stall rises only when a result waits in the output
// register and a second one in the skid register behind it. The sphere is set
// through the APB port; write it only while no ray is in flight.
`include "ray_sphere_intersect_assert.svh"

module ray_sphere_intersect import rsi_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  // Ray requests.
  input  logic              in_valid,
  output logic              in_stall,
  input  rsi_in_t           in_payload,
  // Intersection results.
  output logic              out_valid,
  input  logic              out_stall,
  output rsi_out_t          out_payload,
  // Configuration.
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  logic [COORD_W-1:0] cx_r, cy_r, cz_r;
  logic [R_W-1:0]     r_r;
  logic [IDX_W-1:0]   reg_idx;
  logic               cfg_wr;
  logic               en;
  rsi_cell_t          chain [ROOT_W+1];

  // Register file.
  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r <= CENTER_RESET;
      cy_r <= CENTER_RESET;
      cz_r <= CENTER_RESET;
      r_r  <= RADIUS_RESET;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_CENTER_X: cx_r <= pwdata;
        REG_CENTER_Y: cy_r <= pwdata;
        REG_CENTER_Z: cz_r <= pwdata;
        REG_RADIUS:   r_r  <= pwdata[R_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_CENTER_X: prdata = cx_r;
      REG_CENTER_Y: prdata = cy_r;
      REG_CENTER_Z: prdata = cz_r;
      REG_RADIUS:   prdata = DATA_W'(r_r);
      default:      prdata = '0;
    endcase
  end

  // The whole pipeline holds while the skid register is full.
  assign in_stall = !en;

  // Dot products and discriminant.
  rsi_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .in_valid   (in_valid),
    .in_payload (in_payload),
    .center_x   (cx_r),
    .center_y   (cy_r),
    .center_z   (cz_r),
    .radius     (r_r),
    .head       (chain[0])
  );

  // Square root chain, most significant root bit first.
  for (genvar i = 0; i < ROOT_W; i++) begin : g_cell
    rsi_sqrt_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .cell_in  (chain[i]),
      .cell_out (chain[i+1])
    );
  end

  // Entry distance and result registers.
  rsi_out u_out (
    .clk         (clk),
    .rst_n       (rst_n),
    .tail        (chain[ROOT_W]),
    .out_stall   (out_stall),
    .en          (en),
    .out_valid   (out_valid),
    .out_payload (out_payload)
  );

  // A radius write lands in the register on the next cycle.
  `RSI_ASSERT(a_radius_write, cfg_wr && reg_idx == REG_RADIUS |=> r_r == $past(pwdata[R_W-1:0]))

endmodule
